[design/rsff_pkg.sv]
package rsff_pkg;

    localparam int unsigned DEF_MAX_ROWS  = 1024;
    localparam int unsigned DEF_MAX_SEATS = 65535;

    localparam int unsigned ROW_W   = 10;
    localparam int unsigned SEAT_W  = 16;
    localparam int unsigned SIZE_W  = 26;
    localparam int unsigned NROWS_W = 11;
    localparam int unsigned ADDR_W  = 1;

    localparam logic [ADDR_W-1:0] REG_NUM_ROWS      = 1'b0;
    localparam logic [ADDR_W-1:0] REG_SEATS_PER_ROW = 1'b1;

    localparam logic OP_GATHER  = 1'b0;
    localparam logic OP_SCATTER = 1'b1;

    typedef struct packed {
        logic start;
        logic clear_start;
        logic load_row;
        logic scatter;
    } rsff_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic row_done;
        logic scan_done;
        logic found;
        logic enough;
    } rsff_sts_t;

endpackage

[design/rsff_if.sv]
interface rsff_req_if;
    import rsff_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [SIZE_W-1:0] group_size;
    logic [ROW_W-1:0]  max_row;
    modport source (output valid, opcode, group_size, max_row, input ready);
    modport sink   (input valid, opcode, group_size, max_row, output ready);
endinterface

interface rsff_rsp_if;
    import rsff_pkg::*;
    logic              valid;
    logic              ready;
    logic              granted;
    logic [ROW_W-1:0]  row_index;
    logic [SEAT_W-1:0] seat_index;
    modport source (output valid, granted, row_index, seat_index, input ready);
    modport sink   (input valid, granted, row_index, seat_index, output ready);
endinterface

interface rsff_cfg_if;
    import rsff_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] index;
    logic [15:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/row_seat_first_fit_allocator.sv]
// channel | dir | payload
// req     | in  | opcode, group_size, max_row
// rsp     | out | granted, row_index, seat_index
// cfg     | in  | index, data
// a gather or a refused request is answered after a scan of rows from row 0 upward,
// a gather stopping at its first fit; a granted scatter scans rows 0 to max_row,
// then fills them, max_row clamped to num_rows - 1, reading one row count per cycle
// after reset and after each register write a clearing pass over all MAX_ROWS rows runs
// the next request or register write is taken the cycle after the response is accepted
module row_seat_first_fit_allocator
    import rsff_pkg::*;
#(
    parameter int unsigned MAX_ROWS  = DEF_MAX_ROWS,
    parameter int unsigned MAX_SEATS = DEF_MAX_SEATS
)(
    input logic          clk,
    input logic          rst_n,
    rsff_req_if.sink     req,
    rsff_rsp_if.source   rsp,
    rsff_cfg_if.sink     cfg
);
    logic [NROWS_W-1:0] num_rows_reg;
    logic [SEAT_W-1:0]  seats_reg;
    rsff_cmd_t          cmd;
    rsff_sts_t          sts;
    logic               cfg_fire;
    logic               idle_c;

    assign idle_c    = req.ready && !req.valid;
    assign cfg.ready = idle_c;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NROWS_W'(1024);
            seats_reg    <= SEAT_W'(65535);
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_NUM_ROWS:      num_rows_reg <= NROWS_W'(cfg.data);
                REG_SEATS_PER_ROW: seats_reg    <= cfg.data;
                default:           ;
            endcase
        end
    end

    rsff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_op    (req.opcode),
        .cfg_fire  (cfg_fire),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rsff_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_SEATS(MAX_SEATS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (req.opcode),
        .group_size    (req.group_size),
        .max_row       (req.max_row),
        .num_rows      (num_rows_reg),
        .seats_per_row (seats_reg),
        .res_granted   (rsp.granted),
        .res_row       (rsp.row_index),
        .res_seat      (rsp.seat_index)
    );
endmodule

[design/rsff_datapath.sv]
module rsff_datapath
    import rsff_pkg::*;
#(
    parameter int unsigned MAX_ROWS  = DEF_MAX_ROWS,
    parameter int unsigned MAX_SEATS = DEF_MAX_SEATS
)(
    input  logic              clk,
    input  logic              rst_n,
    input  rsff_cmd_t         cmd,
    output rsff_sts_t         sts,
    input  logic              opcode,
    input  logic [SIZE_W-1:0] group_size,
    input  logic [ROW_W-1:0]  max_row,
    input  logic [NROWS_W-1:0] num_rows,
    input  logic [SEAT_W-1:0] seats_per_row,
    output logic              res_granted,
    output logic [ROW_W-1:0]  res_row,
    output logic [SEAT_W-1:0] res_seat
);
    localparam int unsigned RW = $clog2(MAX_ROWS);
    localparam int unsigned SW = $clog2(MAX_SEATS + 1);
    localparam int unsigned TW = SIZE_W + 1;

    logic [SW-1:0] used_mem [MAX_ROWS];
    logic [RW-1:0] row_reg, lim_reg;
    logic [SW-1:0] rd_reg;
    logic [SW-1:0] seats_reg;
    logic [TW-1:0] left_reg, total_reg;
    logic          op_reg, clr_reg, wr_en;
    logic          res_granted_reg;
    logic [ROW_W-1:0]  res_row_reg;
    logic [SEAT_W-1:0] res_seat_reg;
    logic [SW-1:0] wr_val;
    logic [RW-1:0] lim_c;
    logic [NROWS_W-1:0] n_c;
    logic [SW-1:0] free_c, take_c;
    logic          last_c;

    assign res_granted = res_granted_reg;
    assign res_row     = res_row_reg;
    assign res_seat    = res_seat_reg;

    always_comb
    begin
        n_c = num_rows;
        if (n_c == '0)
            n_c = NROWS_W'(1);
        if (32'(n_c) > MAX_ROWS)
            n_c = NROWS_W'(MAX_ROWS);
        if (32'(max_row) > 32'(n_c) - 1)
            lim_c = RW'(32'(n_c) - 1);
        else
            lim_c = RW'(max_row);
        free_c = (seats_reg > rd_reg) ? seats_reg - rd_reg : '0;
        take_c = (TW'(free_c) < left_reg) ? free_c : SW'(left_reg);
        last_c = (row_reg == lim_reg);
        wr_en  = 1'b0;
        wr_val = rd_reg + take_c;
        if (cmd.load_row && cmd.scatter && take_c != '0)
            wr_en = 1'b1;
        if (cmd.load_row && !cmd.scatter && !op_reg && TW'(free_c) >= left_reg
            && !res_granted_reg)
            wr_en = 1'b1;
        sts.clear_done = clr_reg && (row_reg == RW'(MAX_ROWS - 1));
        sts.row_done   = last_c;
        sts.scan_done  = last_c;
        sts.found      = TW'(free_c) >= left_reg;
        sts.enough     = (total_reg + TW'(free_c)) >= left_reg;
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
            used_mem[row_reg] <= '0;
        else if (wr_en)
            used_mem[row_reg] <= wr_val;
        rd_reg <= used_mem[cmd.start || cmd.clear_start ? RW'(0) :
                           (cmd.load_row && !last_c ? row_reg + RW'(1) : row_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg         <= 1'b1;
            row_reg         <= '0;
            lim_reg         <= '0;
            op_reg          <= 1'b0;
            left_reg        <= '0;
            total_reg       <= '0;
            seats_reg       <= '0;
            res_granted_reg <= 1'b0;
            res_row_reg     <= '0;
            res_seat_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_start)
            begin
                clr_reg <= 1'b1;
                row_reg <= '0;
            end
            else if (clr_reg)
            begin
                if (row_reg == RW'(MAX_ROWS - 1))
                    clr_reg <= 1'b0;
                row_reg <= row_reg + RW'(1);
            end
            else if (cmd.start)
            begin
                row_reg         <= '0;
                lim_reg         <= lim_c;
                op_reg          <= opcode;
                left_reg        <= TW'(group_size);
                total_reg       <= '0;
                seats_reg       <= (32'(seats_per_row) > MAX_SEATS) ? SW'(MAX_SEATS)
                                                                    : SW'(seats_per_row);
                res_granted_reg <= 1'b0;
                res_row_reg     <= '0;
                res_seat_reg    <= '0;
            end
            else if (cmd.load_row)
            begin
                if (!last_c)
                    row_reg <= row_reg + RW'(1);
                if (cmd.scatter)
                    left_reg <= left_reg - TW'(take_c);
                else if (!op_reg)
                begin
                    if (TW'(free_c) >= left_reg && !res_granted_reg)
                    begin
                        res_granted_reg <= 1'b1;
                        res_row_reg     <= ROW_W'(row_reg);
                        res_seat_reg    <= SEAT_W'(rd_reg);
                    end
                end
                else
                begin
                    total_reg <= total_reg + TW'(free_c);
                    if (last_c && (total_reg + TW'(free_c)) >= left_reg)
                    begin
                        res_granted_reg <= 1'b1;
                        row_reg         <= '0;
                    end
                end
            end
        end
    end
endmodule

[design/rsff_ctrl.sv]
module rsff_ctrl
    import rsff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  logic      req_op,
    input  logic      cfg_fire,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsff_cmd_t cmd,
    input  rsff_sts_t sts
)
;
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PRIME, S_SCAN, S_PRIME2, S_FILL, S_DONE}
        state_t;
    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next, op_reg, op_next;

    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        cmd            = '0;
        req_ready      = (state_reg == S_IDLE) && !rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
                if (sts.clear_done)
                    state_next = S_IDLE;
            S_IDLE:
                if (cfg_fire)
                begin
                    cmd.clear_start = 1'b1;
                    state_next      = S_CLEAR;
                end
                else if (req_valid && req_ready)
                begin
                    cmd.start  = 1'b1;
                    op_next    = req_op;
                    state_next = S_PRIME;
                end
            S_PRIME:
                state_next = S_SCAN;
            S_SCAN:
            begin
                cmd.load_row = 1'b1;
                if (op_reg == OP_GATHER && sts.found)
                    state_next = S_DONE;
                else if (sts.scan_done)
                begin
                    if (op_reg == OP_SCATTER && sts.enough)
                        state_next = S_PRIME2;
                    else
                        state_next = S_DONE;
                end
            end
            S_PRIME2:
                state_next = S_FILL;
            S_FILL:
            begin
                cmd.load_row = 1'b1;
                cmd.scatter  = 1'b1;
                if (sts.row_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
            op_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            op_reg        <= op_next;
        end
    end
endmodule

[design/rsff_checker.sv]
module rsff_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_granted,
    input logic [9:0]  rsp_row_index,
    input logic [15:0] rsp_seat_index
);
    a_no_req_while_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("request taken with response pending");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_granted |-> rsp_row_index == '0 && rsp_seat_index == '0)
        else $error("failed request with non-zero fields");
    a_no_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid) else $error("response too early");
endmodule

bind row_seat_first_fit_allocator rsff_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_granted    (rsp.granted),
    .rsp_row_index  (rsp.row_index),
    .rsp_seat_index (rsp.seat_index)
);
